FILE: design/lpht_pkg.sv
// lpht_pkg: shared types and codes for the linear probing hash table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      RS_INSERTED = 3'd0,
      RS_UPDATED  = 3'd1,
      RS_FOUND    = 3'd2,
      RS_MISS     = 3'd3,
      RS_FULL     = 3'd4
   } status_type;

   localparam logic [1:0] SLOT_EMPTY   = 2'd0;
   localparam logic [1:0] SLOT_DELETED = 2'd1;
   localparam logic [1:0] SLOT_FILLED  = 2'd2;

   // widest slot number over the supported table sizes
   localparam int unsigned HOME_BITS = 16;

   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] key;
      logic [31:0] hash_value;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] value_out;
      logic [9:0]  slot_index;
   } rsp_type;

   // classified request as it waits for the probe engine
   typedef struct packed {
      opcode_type           opcode;
      logic [31:0]          key;
      logic [31:0]          value;
      logic [HOME_BITS-1:0] home;
   } job_type;

endpackage
`default_nettype wire

FILE: design/lpht_ram.sv
// lpht_ram: generic one write port, one read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lpht_ram #(
   parameter int unsigned WIDTH = 66,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: design/lpht_front.sv
// lpht_front: accepts request beats and reduces the hash to a home slot
// depends on lpht_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpht_front
   import lpht_pkg::*;
#(
   parameter int unsigned SLOTS = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    hold,
   input  wire logic    q_full,
   output      logic    q_push,
   output      job_type q_data
);
   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned SH    = 32 + IDX_W;
   localparam logic [32:0] RECIP = 33'((65'd1 << SH) / SLOTS);

   logic          v1_ff, v1_in, v2_ff, v2_in;
   req_type       j1_ff, j2_ff;
   logic [64:0]   prod_ff, prod_in;
   logic [IDX_W:0] qs_ff, qs_in;
   logic [31:0]   quot;
   logic [IDX_W:0] rem;
   logic [IDX_W:0] rem_fix;
   logic          move;
   logic          accept;

   assign move      = !(v2_ff && q_full);
   assign req_stall = !move || hold;
   assign accept    = req_valid && !req_stall;

   // quotient estimate is low by at most one
   assign prod_in = {33'd0, req_data.hash_value} * {32'd0, RECIP};
   assign quot    = 32'(prod_ff >> SH);
   assign qs_in   = (IDX_W + 1)'(quot * 32'(SLOTS));
   assign rem     = j2_ff.hash_value[IDX_W:0] - qs_ff;
   assign rem_fix = (rem >= (IDX_W + 1)'(SLOTS)) ? rem - (IDX_W + 1)'(SLOTS) : rem;

   assign v1_in = move ? accept : v1_ff;
   assign v2_in = move ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      if (move) begin
         j1_ff   <= req_data;
         prod_ff <= prod_in;
         j2_ff   <= j1_ff;
         qs_ff   <= qs_in;
      end
   end

   assign q_push        = v2_ff && move;
   assign q_data.opcode = j2_ff.opcode;
   assign q_data.key    = j2_ff.key;
   assign q_data.value  = j2_ff.value;
   assign q_data.home   = HOME_BITS'(IDX_W'(rem_fix));
endmodule
`default_nettype wire

FILE: design/lpht_queue.sv
// lpht_queue: two entry queue between request front and probe engine
// depends on lpht_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpht_queue
   import lpht_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output      logic    full,
   input  wire logic    pop,
   output      logic    not_empty,
   output      job_type head
);
   job_type    ent_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = ent_ff[rd_ff];

   assign rd_in  = rd_ff ^ pop;
   assign wr_in  = wr_ff ^ push;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) begin
         ent_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

FILE: design/lpht_back.sv
// lpht_back: probe engine, slot memory, clearing sweep and result register
// depends on lpht_pkg and lpht_ram
`timescale 1ns / 1ps
`default_nettype none
module lpht_back
   import lpht_pkg::*;
#(
   parameter int unsigned SLOTS      = 1024,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_vld,
   input  wire job_type q_head,
   output      logic    q_pop,
   output      logic    init_busy,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);
   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned W     = 2 + KEY_BITS + VALUE_BITS;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_PROBE = 4'b0010,
      S_CLEAR = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
      wrap_inc = (i == LAST) ? '0 : i + 1'b1;
   endfunction

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in, nxt_ff, nxt_in, exam_ff, exam_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in, clr_ff, clr_in;
   logic             free_vld_ff, free_vld_in, clr_rsp_ff, clr_rsp_in;
   job_type          job_ff, job_in;
   rsp_type          res_ff, res_in, rsp_ff, rsp_in;
   logic             rsp_vld_ff, rsp_vld_in;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic [W-1:0]          wr_data, rd_word;
   logic [1:0]            w_st;
   logic [KEY_BITS-1:0]   w_key, j_key;
   logic [VALUE_BITS-1:0] w_val, j_val;
   logic                  is_empty, is_del, is_hit, done, free_now, load;
   logic [IDX_W-1:0]      free_now_idx;

   lpht_ram #(.WIDTH(W), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign w_st  = rd_word[W-1 -: 2];
   assign w_key = rd_word[VALUE_BITS +: KEY_BITS];
   assign w_val = rd_word[VALUE_BITS-1:0];
   assign j_key = KEY_BITS'(job_ff.key);
   assign j_val = VALUE_BITS'(job_ff.value);

   assign is_empty     = w_st == SLOT_EMPTY;
   assign is_del       = w_st == SLOT_DELETED;
   assign is_hit       = (w_st == SLOT_FILLED) && (w_key == j_key);
   assign done         = is_empty || is_hit || (exam_ff == LAST);
   assign free_now     = free_vld_ff || is_empty || is_del;
   assign free_now_idx = free_vld_ff ? free_idx_ff : rd_idx_ff;

   // home slot is read while idle, later slots stream one per cycle
   assign rd_addr   = (state_ff == S_IDLE) ? IDX_W'(q_head.home) : nxt_ff;
   assign init_busy = (state_ff == S_CLEAR) && !clr_rsp_ff;
   assign load      = !rsp_vld_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      nxt_in      = nxt_ff;
      exam_in     = exam_ff;
      free_idx_in = free_idx_ff;
      free_vld_in = free_vld_ff;
      clr_in      = clr_ff;
      clr_rsp_in  = clr_rsp_ff;
      job_in      = job_ff;
      res_in      = res_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;
      wr_data     = {SLOT_FILLED, j_key, j_val};
      case (state_ff)
         S_IDLE: begin
            if (q_vld) begin
               q_pop  = 1'b1;
               job_in = q_head;
               if (q_head.opcode == OP_CLEAR) begin
                  state_in   = S_CLEAR;
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
               end else begin
                  state_in    = S_PROBE;
                  rd_idx_in   = IDX_W'(q_head.home);
                  nxt_in      = wrap_inc(IDX_W'(q_head.home));
                  exam_in     = '0;
                  free_vld_in = 1'b0;
               end
            end
         end
         S_PROBE: begin
            if (done) begin
               state_in = S_DONE;
               res_in   = '{status: RS_MISS, value_out: 32'd0, slot_index: 10'd0};
               case (job_ff.opcode)
                  OP_INSERT: begin
                     if (is_hit) begin
                        wr_en  = 1'b1;
                        res_in = '{status: RS_UPDATED, value_out: 32'd0,
                                   slot_index: 10'(rd_idx_ff)};
                     end else if (free_now) begin
                        wr_en   = 1'b1;
                        wr_addr = free_now_idx;
                        res_in  = '{status: RS_INSERTED, value_out: 32'd0,
                                    slot_index: 10'(free_now_idx)};
                     end else begin
                        res_in.status = RS_FULL;
                     end
                  end
                  OP_FIND, OP_REMOVE: begin
                     if (is_hit) begin
                        res_in = '{status: RS_FOUND, value_out: 32'(w_val),
                                   slot_index: 10'(rd_idx_ff)};
                        if (job_ff.opcode == OP_REMOVE) begin
                           wr_en   = 1'b1;
                           wr_data = {SLOT_DELETED, w_key, w_val};
                        end
                     end
                  end
                  default: ;
               endcase
            end else begin
               if (!free_vld_ff && is_del) begin
                  free_vld_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               rd_idx_in = nxt_ff;
               nxt_in    = wrap_inc(nxt_ff);
               exam_in   = exam_ff + 1'b1;
            end
         end
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {SLOT_EMPTY, {(KEY_BITS + VALUE_BITS){1'b0}}};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               if (clr_rsp_ff) begin
                  state_in = S_DONE;
                  res_in   = '{status: RS_FOUND, value_out: 32'd0, slot_index: 10'd0};
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DONE: begin
            if (load) begin
               rsp_in     = res_ff;
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rd_idx_ff   <= rd_idx_in;
      nxt_ff      <= nxt_in;
      exam_ff     <= exam_in;
      free_idx_ff <= free_idx_in;
      free_vld_ff <= free_vld_in;
      job_ff      <= job_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

FILE: design/linear_probe_hash_table.sv
// path: hash reduction in the front, the queue, a home read, slots probed in turn,
// then the result and output registers; a clear sweeps every slot before its response
// throughput: one request at a time in the probe engine, set by probe length
// reset: a sweep over every slot empties the slot memory; requests stall meanwhile
// depends on lpht_pkg, lpht_front, lpht_queue, lpht_back, lpht_ram
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int unsigned SLOTS      = 1024,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);
   logic    q_full, q_push, q_pop, q_vld, init_busy;
   job_type q_in, q_head;

   lpht_front #(.SLOTS(SLOTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .hold      (init_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   lpht_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_vld),
      .head      (q_head)
   );

   lpht_back #(
      .SLOTS      (SLOTS),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_vld     (q_vld),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into full queue");

   a_init_stalls: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> req_stall) else $error("request taken during clearing sweep");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_vld) else $error("pop from empty queue");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == RS_MISS || rsp_data.status == RS_FULL ||
                    rsp_data.status == RS_INSERTED || rsp_data.status == RS_UPDATED)
      |-> rsp_data.value_out == 32'd0) else $error("value on a result without one");
endmodule
`default_nettype wire

FILE: tb/lpht_checker.sv
// lpht_checker: watches both channels of the hash table, predicts each response
// from its own slot model and compares field by field; depends on lpht_pkg
`timescale 1ns / 1ps
module lpht_checker
   import lpht_pkg::*;
#(
   parameter int unsigned SLOTS = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count,
   output int           rsp_count
);

   logic [1:0]  table_state [SLOTS];
   logic [31:0] table_key   [SLOTS];
   logic [31:0] table_value [SLOTS];
   rsp_type     expected_rsps [$];

   initial begin
      fail_count = 0;
      rsp_count  = 0;
      for (int i = 0; i < SLOTS; i++) begin
         table_state[i] = SLOT_EMPTY;
         table_key[i]   = '0;
         table_value[i] = '0;
      end
   end

   assign pending_count = expected_rsps.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic rsp_type apply_request(input req_type rq);
      rsp_type r;
      int unsigned idx;
      int hit;
      int free_slot;
      r = '{status: RS_MISS, value_out: '0, slot_index: '0};
      hit = -1;
      free_slot = -1;
      idx = rq.hash_value % SLOTS;
      if (rq.opcode == OP_CLEAR) begin
         for (int i = 0; i < SLOTS; i++) table_state[i] = SLOT_EMPTY;
         r.status = RS_FOUND;
         return r;
      end
      for (int n = 0; n < SLOTS; n++) begin
         if (table_state[idx] == SLOT_EMPTY) begin
            if (free_slot < 0) free_slot = idx;
            break;
         end
         if (table_state[idx] == SLOT_DELETED) begin
            if (free_slot < 0) free_slot = idx;
         end else if (table_key[idx] == rq.key) begin
            hit = idx;
            break;
         end
         idx = (idx + 1) % SLOTS;
      end
      if (rq.opcode == OP_INSERT) begin
         if (hit >= 0) begin
            table_value[hit] = rq.value;
            r.status = RS_UPDATED;
            r.slot_index = hit[9:0];
         end else if (free_slot >= 0) begin
            table_state[free_slot] = SLOT_FILLED;
            table_key[free_slot]   = rq.key;
            table_value[free_slot] = rq.value;
            r.status = RS_INSERTED;
            r.slot_index = free_slot[9:0];
         end else begin
            r.status = RS_FULL;
         end
      end else if (hit >= 0) begin
         r.status = RS_FOUND;
         r.value_out = table_value[hit];
         r.slot_index = hit[9:0];
         if (rq.opcode == OP_REMOVE) table_state[hit] = SLOT_DELETED;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_rsps.push_back(apply_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected beat", {29'd0, rsp_data.status}, '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", {29'd0, rsp_data.status}, {29'd0, want.status});
               if (rsp_data.value_out != want.value_out)
                  report_mismatch("value_out", rsp_data.value_out, want.value_out);
               if (rsp_data.slot_index != want.slot_index)
                  report_mismatch("slot_index", {22'd0, rsp_data.slot_index},
                                  {22'd0, want.slot_index});
            end
         end
      end
   end

endmodule

FILE: tb/tb_linear_probe_hash_table.sv
// tb_linear_probe_hash_table: drives directed and random table traffic with
// random gaps and stalls; depends on lpht_pkg, lpht_checker and the block
`timescale 1ns / 1ps
module tb_linear_probe_hash_table;
   import lpht_pkg::*;

   localparam int unsigned SLOTS = 1024;
   localparam int          CYCLE_LIMIT = 10_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending_count, rsp_count;
   int      cycle_count = 0;
   int      item_count = 0;
   bit      hold_rsp = 1'b0;
   logic [31:0] key_pool [16];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   linear_probe_hash_table #(.SLOTS(SLOTS)) dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   lpht_checker #(.SLOTS(SLOTS)) checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .fail_count, .pending_count, .rsp_count
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // receiver stall: random, with stall-free windows and a long hold-off forced by hold_rsp
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (cycle_count % 2000 < 300) rsp_stall <= 1'b0;
      else rsp_stall <= (gap_len() != 0);
   end

   task automatic send(input opcode_type op, input logic [31:0] k,
                       input logic [31:0] h, input logic [31:0] v);
      int g;
      req_valid <= 1'b1;
      req_data  <= '{opcode: op, key: k, hash_value: h, value: v};
      do @(posedge clock); while (req_stall);
      item_count++;
      g = (cycle_count % 3000 < 400) ? 0 : gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic random_item(input int unsigned hash_span);
      int r;
      opcode_type op;
      logic [31:0] k;
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_INSERT;
      else if (r < 75) op = OP_FIND;
      else if (r < 99) op = OP_REMOVE;
      else op = OP_CLEAR;
      k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 15)];
      // hashes mostly collide into a small window to build long probe chains
      send(op, k, ($urandom_range(0, 3) == 0) ? $urandom()
                  : (k[7:0] % hash_span) + ($urandom() & 32'hFFFF_FC00), $urandom());
   endtask

   initial begin
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, wraparound, update, tombstone reuse, clear
      send(OP_FIND,   32'h0,         32'h0,         32'h0);
      send(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(OP_INSERT, 32'h0,         32'h0000_03FF, 32'h1234_5678);
      send(OP_INSERT, 32'h5,         32'h0000_03FF, 32'hAAAA_5555);
      send(OP_FIND,   32'h5,         32'hFFFF_FFFF, 32'h0);
      send(OP_INSERT, 32'h0,         32'h0000_07FF, 32'h5555_AAAA);
      send(OP_REMOVE, 32'h0,         32'h0000_03FF, 32'h0);
      send(OP_FIND,   32'h5,         32'h0000_03FF, 32'h0);
      send(OP_INSERT, 32'h5,         32'h0000_03FF, 32'h0BAD_F00D);
      send(OP_INSERT, 32'h9,         32'h0000_03FF, 32'h0000_0009);
      send(OP_REMOVE, 32'h0,         32'h0000_03FF, 32'h0);
      send(OP_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(OP_FIND,   32'h5,         32'h0000_03FF, 32'h0);
      drain();
      // fill the whole table, then insert into a full table and walk it
      for (int i = 0; i < SLOTS; i++) send(OP_INSERT, i + 32'h100, 32'h7, i);
      send(OP_INSERT, 32'hDEAD_BEEF, 32'h7, 32'h1);
      send(OP_FIND,   32'hDEAD_BEEF, 32'h3, 32'h0);
      send(OP_REMOVE, 32'h105,       32'h0, 32'h0);
      send(OP_FIND,   32'hDEAD_BEEF, 32'h9, 32'h0);
      send(OP_INSERT, 32'hDEAD_BEEF, 32'h9, 32'h2);
      send(OP_CLEAR,  32'h0,         32'h0, 32'h0);
      // receiver holds off while sender keeps offering
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (200) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            for (int i = 0; i < 20; i++) random_item(16);
            req_valid <= 1'b0;
         end
      join
      drain();
      for (int i = 0; i < 580; i++) random_item((i < 300) ? 8 : 64);
      send(OP_CLEAR, 32'h0, 32'h0, 32'h0);
      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d responses checked, including full table,",
               item_count, rsp_count);
      $display("wraparound, tombstone reuse, clears and long receiver stalls");
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
